// File: hdl/v2dt_pkg.sv
// v2dt_pkg: shared types, codes and constants for the 2D vertex transform.
// Holds the quarter-wave sine table (16 fraction bits) and the angle folding
// helper. No dependencies.
package v2dt_pkg;

	// Transform mode codes
	typedef enum logic [2:0] {
		MODE_TRANSLATE = 3'd0,
		MODE_ROTATE    = 3'd1,
		MODE_SCALE     = 3'd2,
		MODE_REFLECT_X = 3'd3,
		MODE_REFLECT_Y = 3'd4
	} mode_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_OFFSET_X = 3'd1,
		REG_OFFSET_Y = 3'd2,
		REG_SCALE_X  = 3'd3,
		REG_SCALE_Y  = 3'd4,
		REG_ANGLE    = 3'd5,
		REG_SCREEN_X = 3'd6,
		REG_SCREEN_Y = 3'd7
	} reg_idx_t;

	localparam int REG_IDX_BITS = 3;
	localparam int CFG_BITS     = 12;
	localparam int MODE_BITS    = 3;
	localparam int OFFSET_BITS  = 12;
	localparam int SCALE_BITS   = 8;
	localparam int ANGLE_BITS   = 9;
	localparam int SCREEN_BITS  = 12;
	localparam int OUT_BITS     = 16;
	localparam int OUT_MAX      = 32767;
	localparam int OUT_MIN      = -32768;

	localparam logic [SCALE_BITS-1:0]  SCALE_RESET    = 8'd1;
	localparam logic [SCREEN_BITS-1:0] SCREEN_X_RESET = 12'd639;
	localparam logic [SCREEN_BITS-1:0] SCREEN_Y_RESET = 12'd479;

	localparam int SIN_Q16_BITS = 17;
	localparam int SIN_IDX_BITS = 7;

	// round(65536 * sin(d degrees)) for d = 0..90
	localparam logic [SIN_Q16_BITS-1:0] SIN_Q16 [0:90] = '{
		17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
		17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
		17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
		17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
		17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
		17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
		17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
		17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
		17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
		17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
		17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
		17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
		17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
	};

	// Sign and first-quadrant index of an angle in 0..359
	typedef struct packed {
		logic                    neg;
		logic [SIN_IDX_BITS-1:0] idx;
	} fold_t;

	function automatic fold_t fold_angle(input logic [ANGLE_BITS-1:0] deg);
		fold_t                 f;
		logic [ANGLE_BITS-1:0] d;
		f.neg = (deg >= ANGLE_BITS'(180));
		d     = f.neg ? deg - ANGLE_BITS'(180) : deg;
		f.idx = (d > ANGLE_BITS'(90)) ? SIN_IDX_BITS'(ANGLE_BITS'(180) - d)
		                              : SIN_IDX_BITS'(d);
		return f;
	endfunction

endpackage

// File: hdl/vertex_2d_transform.sv
// vertex_2d_transform: four-stage pipeline that translates, rotates, scales or
// reflects one vertex per cycle while out_ready is high. Depends on v2dt_pkg.
//
// Usage:
//   Configure through cfg_we / cfg_index / cfg_data while no request is in
//   flight; registers take effect for the next vertex accepted.
//   Vertices enter on in_valid / in_ready and leave on out_valid / out_ready,
//   one result per request, in order, with last_out copied from last_vertex.
//   Throughput is one vertex per cycle while out_ready is high. The stages
//   are: trig lookup and operand select, the four multipliers, the rotation
//   sums, then round rotation results toward zero and saturate into the
//   output register.
//   When out_ready is low the pipeline keeps accepting until every stage is
//   full, collapsing bubbles; no request is dropped or repeated.
//   Reset clears all stage valid bits and loads the register reset values:
//   translate mode, zero offsets, unit scale, zero angle, screen 639 x 479.
//   The block is ready for requests in the first cycle after reset.
module vertex_2d_transform #(
	parameter int COORD_BITS         = 12,
	parameter int TRIG_FRACTION_BITS = 14
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// configuration port
	input  logic                                       cfg_we,
	input  logic [v2dt_pkg::REG_IDX_BITS-1:0]          cfg_index,
	input  logic [v2dt_pkg::CFG_BITS-1:0]              cfg_data,
	// vertex requests
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic signed [COORD_BITS-1:0]               vertex_x,
	input  logic signed [COORD_BITS-1:0]               vertex_y,
	input  logic                                       last_vertex,
	// results
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [v2dt_pkg::OUT_BITS-1:0]       new_x,
	output logic signed [v2dt_pkg::OUT_BITS-1:0]       new_y,
	output logic                                       last_out,
	output logic                                       saturated
);
	import v2dt_pkg::*;

	localparam int F    = TRIG_FRACTION_BITS;
	localparam int SH   = 16 - F;
	localparam int RND  = (SH == 0) ? 0 : (1 << (SH - 1));
	localparam int MAGW = F + 1;
	localparam int CW   = F + 2;
	localparam int PW   = COORD_BITS + CW;
	localparam int W    = PW + 1;

	localparam logic signed [W-1:0] SAT_HI = W'(OUT_MAX);
	localparam logic signed [W-1:0] SAT_LO = W'(OUT_MIN);
	localparam logic signed [W-1:0] BIAS   = W'((1 << F) - 1);

	// Configuration registers
	logic [MODE_BITS-1:0]          mode_q;
	logic signed [OFFSET_BITS-1:0] offset_x_q;
	logic signed [OFFSET_BITS-1:0] offset_y_q;
	logic signed [SCALE_BITS-1:0]  scale_x_q;
	logic signed [SCALE_BITS-1:0]  scale_y_q;
	logic [ANGLE_BITS-1:0]         angle_q;
	logic [SCREEN_BITS-1:0]        screen_x_q;
	logic [SCREEN_BITS-1:0]        screen_y_q;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_TRANSLATE;
			offset_x_q <= '0;
			offset_y_q <= '0;
			scale_x_q  <= SCALE_RESET;
			scale_y_q  <= SCALE_RESET;
			angle_q    <= '0;
			screen_x_q <= SCREEN_X_RESET;
			screen_y_q <= SCREEN_Y_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[MODE_BITS-1:0];
				REG_OFFSET_X: offset_x_q <= cfg_data[OFFSET_BITS-1:0];
				REG_OFFSET_Y: offset_y_q <= cfg_data[OFFSET_BITS-1:0];
				REG_SCALE_X:  scale_x_q  <= cfg_data[SCALE_BITS-1:0];
				REG_SCALE_Y:  scale_y_q  <= cfg_data[SCALE_BITS-1:0];
				REG_ANGLE:    angle_q    <= cfg_data[ANGLE_BITS-1:0];
				REG_SCREEN_X: screen_x_q <= cfg_data[SCREEN_BITS-1:0];
				REG_SCREEN_Y: screen_y_q <= cfg_data[SCREEN_BITS-1:0];
				default:      mode_q     <= mode_q;
			endcase
		end
	end

	// Stage valid bits and flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: sine and cosine from the angle register, and multiplier operand select
	logic [ANGLE_BITS-1:0]   ang_w;
	logic [ANGLE_BITS:0]     cos_sum;
	logic [ANGLE_BITS-1:0]   cos_deg;
	fold_t                   sin_f, cos_f;
	logic [SIN_Q16_BITS:0]   sin_rnd, cos_rnd;
	logic [MAGW-1:0]         sin_mag, cos_mag;
	logic signed [CW-1:0]    sin_c, cos_c;
	logic signed [CW-1:0]    ca_c, cb_c;

	always_comb begin
		ang_w   = (angle_q >= ANGLE_BITS'(360)) ? angle_q - ANGLE_BITS'(360) : angle_q;
		cos_sum = (ANGLE_BITS + 1)'(ang_w) + (ANGLE_BITS + 1)'(90);
		cos_deg = (cos_sum >= (ANGLE_BITS + 1)'(360))
		        ? ANGLE_BITS'(cos_sum - (ANGLE_BITS + 1)'(360))
		        : ANGLE_BITS'(cos_sum);
		sin_f   = fold_angle(ang_w);
		cos_f   = fold_angle(cos_deg);
		sin_rnd = (SIN_Q16_BITS + 1)'(SIN_Q16[sin_f.idx]) + (SIN_Q16_BITS + 1)'(RND);
		cos_rnd = (SIN_Q16_BITS + 1)'(SIN_Q16[cos_f.idx]) + (SIN_Q16_BITS + 1)'(RND);
		sin_mag = sin_rnd[SH +: MAGW];
		cos_mag = cos_rnd[SH +: MAGW];
		sin_c   = sin_f.neg ? -$signed(CW'(sin_mag)) : $signed(CW'(sin_mag));
		cos_c   = cos_f.neg ? -$signed(CW'(cos_mag)) : $signed(CW'(cos_mag));
		// scale shares the x*ca and y*cb multipliers
		if (mode_q == MODE_SCALE) begin
			ca_c = CW'(scale_x_q);
			cb_c = CW'(scale_y_q);
		end else begin
			ca_c = cos_c;
			cb_c = cos_c;
		end
	end

	logic signed [COORD_BITS-1:0] x_s1, y_s1;
	logic                         last_s1;
	logic [MODE_BITS-1:0]         mode_s1;
	logic signed [CW-1:0]         ca_s1, cb_s1, sn_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			x_s1    <= vertex_x;
			y_s1    <= vertex_y;
			last_s1 <= last_vertex;
			mode_s1 <= mode_q;
			ca_s1   <= ca_c;
			cb_s1   <= cb_c;
			sn_s1   <= sin_c;
		end
	end

	// Stage 2: products, plus translate and reflect results
	logic signed [W-1:0] sx_c, sy_c;

	always_comb begin
		sx_c = W'(x_s1);
		sy_c = W'(y_s1);
		unique case (mode_s1)
			MODE_TRANSLATE: begin
				sx_c = W'(x_s1) + W'(offset_x_q);
				sy_c = W'(y_s1) + W'(offset_y_q);
			end
			MODE_REFLECT_X: sy_c = $signed(W'(screen_y_q)) - W'(y_s1);
			MODE_REFLECT_Y: sx_c = $signed(W'(screen_x_q)) - W'(x_s1);
			default: begin
				sx_c = W'(x_s1);
				sy_c = W'(y_s1);
			end
		endcase
	end

	logic signed [PW-1:0]  p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [W-1:0]   sx_s2, sy_s2;
	logic                  last_s2;
	logic [MODE_BITS-1:0]  mode_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			p0_s2   <= PW'(x_s1) * PW'(ca_s1);
			p1_s2   <= PW'(y_s1) * PW'(sn_s1);
			p2_s2   <= PW'(y_s1) * PW'(cb_s1);
			p3_s2   <= PW'(x_s1) * PW'(sn_s1);
			sx_s2   <= sx_c;
			sy_s2   <= sy_c;
			last_s2 <= last_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: rotation sums and result select
	logic signed [W-1:0] vx_c, vy_c;

	always_comb begin
		unique case (mode_s2)
			MODE_ROTATE: begin
				vx_c = W'(p0_s2) + W'(p1_s2);
				vy_c = W'(p2_s2) - W'(p3_s2);
			end
			MODE_SCALE: begin
				vx_c = W'(p0_s2);
				vy_c = W'(p2_s2);
			end
			default: begin
				vx_c = sx_s2;
				vy_c = sy_s2;
			end
		endcase
	end

	logic signed [W-1:0] vx_s3, vy_s3;
	logic                rot_s3, last_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			vx_s3   <= vx_c;
			vy_s3   <= vy_c;
			rot_s3  <= (mode_s2 == MODE_ROTATE);
			last_s3 <= last_s2;
		end
	end

	// Stage 4: drop fraction bits toward zero for rotation, then saturate
	logic signed [W-1:0]        tx_c, ty_c;
	logic signed [OUT_BITS-1:0] ox_c, oy_c;
	logic                       clip_x, clip_y;

	always_comb begin
		tx_c = rot_s3 ? ((vx_s3 + (vx_s3[W-1] ? BIAS : W'(0))) >>> F) : vx_s3;
		ty_c = rot_s3 ? ((vy_s3 + (vy_s3[W-1] ? BIAS : W'(0))) >>> F) : vy_s3;

		clip_x = 1'b1;
		if (tx_c > SAT_HI)      ox_c = OUT_BITS'(OUT_MAX);
		else if (tx_c < SAT_LO) ox_c = OUT_BITS'(OUT_MIN);
		else begin
			ox_c   = tx_c[OUT_BITS-1:0];
			clip_x = 1'b0;
		end

		clip_y = 1'b1;
		if (ty_c > SAT_HI)      oy_c = OUT_BITS'(OUT_MAX);
		else if (ty_c < SAT_LO) oy_c = OUT_BITS'(OUT_MIN);
		else begin
			oy_c   = ty_c[OUT_BITS-1:0];
			clip_y = 1'b0;
		end
	end

	logic signed [OUT_BITS-1:0] x_s4, y_s4;
	logic                       last_s4, sat_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			x_s4    <= ox_c;
			y_s4    <= oy_c;
			last_s4 <= last_s3;
			sat_s4  <= clip_x || clip_y;
		end
	end

	assign out_valid = v_s4;
	assign new_x     = x_s4;
	assign new_y     = y_s4;
	assign last_out  = last_s4;
	assign saturated = sat_s4;

	// Checks
	logic [2:0] occ;
	logic       acc_in, acc_out;

	assign occ     = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	// requests in flight change only by acceptance and delivery
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> occ == $past(occ) + 3'($past(acc_in)) - 3'($past(acc_out)))
		else $error("pipeline occupancy lost or duplicated a request");

	// input stalls only with every stage full
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled with a free stage");

	// a clipped result sits at a range bound
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
		(new_x == OUT_BITS'(OUT_MAX) || new_x == OUT_BITS'(OUT_MIN) ||
		 new_y == OUT_BITS'(OUT_MAX) || new_y == OUT_BITS'(OUT_MIN)))
		else $error("saturated flag without a bound value");

	// zero angle gives unit cosine and zero sine
	assert property (@(posedge clk) disable iff (!arst_n)
		(angle_q == '0) |-> (cos_c == $signed(CW'(1 << F)) && sin_c == '0))
		else $error("trig lookup wrong at zero angle");

endmodule
